@@ rtl/mavg_pkg.sv @@
// Package for the moving average filter: field widths, divider sizing and
// the sequencer state type. Has no dependencies.

package mavg_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 24;
    localparam int WIN_W     = 8;
    localparam int QUOT_W    = 16;
    localparam int DIV_STEPS = QUOT_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DONE
    } mavg_state_t;

endpackage

@@ rtl/mavg_div.sv @@
// Iterative signed-by-unsigned divider for the moving average filter.
// Produces one quotient bit per cycle; depends on mavg_pkg.

module mavg_div
    import mavg_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic        [WIN_W-1:0] divisor,
    output logic                     done,
    output logic signed [QUOT_W-1:0] quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] count_reg, count_next;
    logic              neg_reg, neg_next;
    logic [WIN_W-1:0]  rem_reg, rem_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;

    logic [SUM_W-1:0]  magnitude;
    logic [WIN_W:0]    trial;
    logic [WIN_W:0]    diff;
    logic              fits;

    // The magnitude of a window mean fits in QUOT_W bits, so the upper
    // dividend bits are always below the divisor and seed the remainder.
    assign magnitude = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
    assign trial     = {rem_reg, quot_reg[QUOT_W-1]};
    assign diff      = trial - {1'b0, divisor};
    assign fits      = (trial >= {1'b0, divisor});

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        neg_next   = neg_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        if (start) begin
            busy_next  = 1'b1;
            count_next = '0;
            neg_next   = dividend[SUM_W-1];
            rem_next   = magnitude[SUM_W-1 -: WIN_W];
            quot_next  = magnitude[QUOT_W-1:0];
        end else if (busy_reg) begin
            rem_next   = fits ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
            quot_next  = {quot_reg[QUOT_W-2:0], fits};
            count_next = count_reg + 1'b1;
            if (count_reg == STEP_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        count_reg <= count_next;
        neg_reg   <= neg_next;
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? QUOT_W'(-quot_reg) : QUOT_W'(quot_reg);

endmodule

@@ rtl/moving_average_filter.sv @@
// Moving average filter top level: ring store, running sum and sequencer.
// Depends on mavg_pkg and mavg_div.
//
// Usage:
// Samples enter on the s_ channel (s_valid, s_ready, s_sample) and each one
// yields exactly one item on the m_ channel (m_valid, m_ready, m_average),
// the mean of the last window_size samples truncated toward zero.
// The window is set through cfg_wr_en and cfg_wr_data while the block is idle.
// A write clears the window, so the output ramps up again from zero.
// A window of zero gives an average of zero and leaves the window untouched.
// Steps: an accepted item first passes ST_UPDATE, which updates the running
// sum and starts the divider; the divider resolves one quotient bit per cycle,
// the quotient is taken in ST_DIVIDE, and ST_DONE hands it to the output
// register. A window of zero goes straight to ST_DONE. One item is in work at
// a time, so a new sample is taken only once the last one has left ST_DONE.
// s_ready is high when the sequencer is idle and no window write is under
// way, so the next item may be taken while the previous result still waits
// in the output register.
// If the receiver stalls, the finished result waits in the sequencer until
// the output register is free; no item is dropped.
// Reset clears the window size, the ring index and the running sum. Stored
// samples are masked until the ring has wrapped once, so no clearing pass.

module moving_average_filter
    import mavg_pkg::*;
#(
    parameter int MAX_POINTS = 256
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic        [WIN_W-1:0]   cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [QUOT_W-1:0]  m_average
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CMP_W = WIN_W + 1;
    localparam logic [CMP_W-1:0] MaxWin = CMP_W'(MAX_POINTS);

    mavg_state_t state_reg, state_next;

    logic [WIN_W-1:0]           window_reg, window_next;
    logic [IDX_W-1:0]           index_reg, index_next;
    logic                       wrapped_reg, wrapped_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic signed [QUOT_W-1:0]   avg_reg, avg_next;
    logic                       m_valid_reg, m_valid_next;
    logic signed [QUOT_W-1:0]   m_average_reg, m_average_next;

    logic signed [SAMPLE_W-1:0] store_mem [MAX_POINTS];

    logic [WIN_W-1:0]        win_eff;
    logic [CMP_W-1:0]        index_inc;
    logic                    index_wrap;
    logic signed [SAMPLE_W-1:0] old_sample;
    logic                    accept;
    logic                    div_start;
    logic                    div_done;
    logic signed [QUOT_W-1:0] div_quot;

    assign win_eff    = ({1'b0, window_reg} > MaxWin) ? WIN_W'(MAX_POINTS) : window_reg;
    assign index_inc  = CMP_W'(index_reg) + CMP_W'(1);
    assign index_wrap = (index_inc >= {1'b0, win_eff});
    assign old_sample = wrapped_reg ? rd_data_reg : '0;
    assign accept     = s_valid && s_ready;
    assign s_ready    = (state_reg == ST_IDLE) && !cfg_wr_en;

    always_comb begin
        state_next     = state_reg;
        window_next    = window_reg;
        index_next     = index_reg;
        wrapped_next   = wrapped_reg;
        sum_next       = sum_reg;
        avg_next       = avg_reg;
        m_valid_next   = m_valid_reg;
        m_average_next = m_average_reg;
        div_start      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_wr_en) begin
                    window_next  = cfg_wr_data;
                    index_next   = '0;
                    wrapped_next = 1'b0;
                    sum_next     = '0;
                end else if (accept) begin
                    if (win_eff == '0) begin
                        avg_next   = '0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE: begin
                sum_next   = sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
                index_next = index_wrap ? '0 : IDX_W'(index_inc);
                if (index_wrap) begin
                    wrapped_next = 1'b1;
                end
                div_start  = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    avg_next   = div_quot;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_average_next = avg_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            window_reg  <= '0;
            index_reg   <= '0;
            wrapped_reg <= 1'b0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            window_reg  <= window_next;
            index_reg   <= index_next;
            wrapped_reg <= wrapped_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
        avg_reg       <= avg_next;
        m_average_reg <= m_average_next;
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg  <= s_sample;
            rd_data_reg <= store_mem[index_reg];
        end
        if (state_reg == ST_UPDATE) begin
            store_mem[index_reg] <= sample_reg;
        end
    end

    mavg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (win_eff),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign m_valid   = m_valid_reg;
    assign m_average = m_average_reg;

endmodule

@@ sim/tb_top.sv @@
// Testbench for moving_average_filter: a scoreboard class predicts each average
// from its own ring store, and plain tasks drive samples and window writes.
// Depends on mavg_pkg and the moving_average_filter RTL.
`timescale 1ns / 100ps

module tb_top
    import mavg_pkg::*;
();

    localparam int MAX_POINTS = 256;

    class mavg_scoreboard;
        int unsigned window;
        logic signed [SAMPLE_W-1:0] slots [MAX_POINTS];
        int unsigned wr_idx;
        int window_sum;
        logic signed [QUOT_W-1:0] expected_avgs [$];
        int errors;
        int received;

        function new();
            errors = 0;
            received = 0;
            set_window(0);
        endfunction

        function void set_window(int unsigned w);
            window = (w > MAX_POINTS) ? MAX_POINTS : w;
            foreach (slots[i]) slots[i] = '0;
            wr_idx = 0;
            window_sum = 0;
        endfunction

        function int pending();
            return expected_avgs.size();
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] value);
            int avg;
            avg = 0;
            if (window != 0) begin
                if (wr_idx >= window) wr_idx = 0;
                window_sum = window_sum - int'(slots[wr_idx]) + int'(value);
                slots[wr_idx] = value;
                wr_idx++;
                if (wr_idx >= window) wr_idx = 0;
                avg = window_sum / int'(window);
            end
            expected_avgs.push_back(avg[QUOT_W-1:0]);
        endfunction

        function void check_average(logic signed [QUOT_W-1:0] actual);
            logic signed [QUOT_W-1:0] want;
            received++;
            if (expected_avgs.size() == 0) begin
                $error("average: no item expected, actual %0d", actual);
                errors++;
            end else begin
                want = expected_avgs.pop_front();
                if (actual !== want) begin
                    $error("average: expected %0d, actual %0d", want, actual);
                    errors++;
                end
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [WIN_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [SAMPLE_W-1:0] s_sample = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [QUOT_W-1:0] m_average;

    mavg_scoreboard sb = new();
    int burst_left = 0;
    bit sender_gaps = 1'b1;

    moving_average_filter #(.MAX_POINTS(MAX_POINTS)) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_sample(s_sample),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_average(m_average)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_average(m_average);
    end

    initial begin : receiver
        int cyc;
        int hold;
        bit hold_done;
        cyc = 0;
        hold = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            cyc++;
            // One long stall so the block fills up and pushes back on its input.
            if (!hold_done && sb.received >= 150) begin
                hold = 400;
                hold_done = 1'b1;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                case ((cyc / 97) % 4)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= (cyc % 4 == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            if (sender_gaps) begin
                gap = $urandom_range(1, 25);
                repeat (gap) begin
                    @(negedge aclk);
                    s_valid <= 1'b0;
                end
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_sample <= value;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(value);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] w);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= w;
        @(posedge aclk);
        sb.set_window(w);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input logic [WIN_W-1:0] w, input int count, input int mode,
                             input bit gaps);
        logic signed [SAMPLE_W-1:0] value;
        write_window(w);
        sender_gaps = gaps;
        repeat (count) begin
            value = SAMPLE_W'($urandom);
            if (mode == 1) begin
                case ($urandom_range(0, 5))
                    0: value = 16'sh8000;
                    1: value = 16'sh7fff;
                    2: value = 16'sh0000;
                    3: value = -16'sd1;
                    4: value = 16'sd1;
                    default: ;
                endcase
            end else if (mode == 2 && $urandom_range(0, 15) != 0) begin
                value = 16'sh8000;
            end
            send_sample(value);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // The window is zero out of reset, so every average is zero.
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(-16'sd1);

        write_window(8'd1);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sh5555);
        send_sample(16'shaaaa);
        send_sample(-16'sd1);

        write_window(8'd255);
        repeat (3) send_sample(16'sh7fff);
        repeat (3) send_sample(16'sh8000);

        write_window(8'd2);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sh7fff);
        send_sample(-16'sd1);
        send_sample(16'sd0);

        write_window(8'd0);
        send_sample(16'sd5);
        send_sample(-16'sd5);

        run_phase(8'd255, 280, 2, 1'b1);
        run_phase(WIN_W'($urandom_range(3, 254)), 60, 0, 1'b0);
        run_phase(8'd0, 15, 0, 1'b1);
        run_phase(8'd1, 30, 1, 1'b1);
        run_phase(WIN_W'($urandom_range(2, 16)), 60, 1, 1'b1);
        run_phase(WIN_W'($urandom_range(17, 254)), 60, 0, 1'b1);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
